>>> rtl/sjfq_pkg.sv
// Package: shared constants, codes and types of the shortest-job-first queue.
`default_nettype none
package sjfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 5;
    localparam int TIME_W      = 16;
    localparam int SUM_W       = 20;
    localparam int STATUS_W    = 2;

    localparam logic [TAG_W-1:0]    POS_MAX = {TAG_W{1'b1}};
    localparam logic [SUM_W-1:0]    SUM_MAX = {SUM_W{1'b1}};

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } sjfq_cmd_t;

endpackage
`default_nettype wire

>>> rtl/sjfq_ctrl.sv
// Controller: sequences capture, execution and the output register handshake.
`default_nettype none
module sjfq_ctrl
    import sjfq_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire       m_tready,
    output sjfq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.capture    = 1'b0;
        cmd.execute    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // run only once the output register is free or being drained
                if (!out_valid_reg || m_tready) begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sjfq_dp.sv
// Datapath: sorted slot array, service counters and the result register.
`default_nettype none
module sjfq_dp
    import sjfq_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sjfq_cmd_t           cmd,
    input  wire                 in_kind,
    input  wire  [TIME_W-1:0]   in_time,
    output logic [STATUS_W-1:0] out_status,
    output logic [TAG_W-1:0]    out_tag,
    output logic [TIME_W-1:0]   out_time,
    output logic [SUM_W-1:0]    out_wait_sum,
    output logic                out_late,
    output logic [TAG_W-1:0]    out_occupancy
);

    logic                kind_reg;
    logic [TIME_W-1:0]   time_reg;

    logic [TIME_W-1:0]   slot_time_reg [QUEUE_DEPTH];
    logic [TAG_W-1:0]    slot_tag_reg  [QUEUE_DEPTH];
    logic [TIME_W-1:0]   slot_time_next[QUEUE_DEPTH];
    logic [TAG_W-1:0]    slot_tag_next [QUEUE_DEPTH];

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic [TAG_W-1:0]    pos_reg, pos_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [TIME_W-1:0]   otime_reg, otime_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                late_reg, late_next;
    logic [TAG_W-1:0]    occ_reg, occ_next;

    logic [QUEUE_DEPTH-1:0] keep;
    logic [TAG_W-1:0]       new_tag;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [TAG_W-1:0]       pos_inc;
    logic                   full;

    assign out_status    = status_reg;
    assign out_tag       = tag_reg;
    assign out_time      = otime_reg;
    assign out_wait_sum  = sum_reg;
    assign out_late      = late_reg;
    assign out_occupancy = occ_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign new_tag  = TAG_W'(count_reg) + TAG_W'(1);
    assign sum_wide = {1'b0, total_reg} + (SUM_W+1)'(slot_time_reg[0]);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign pos_inc  = (pos_reg < POS_MAX) ? pos_reg + TAG_W'(1) : pos_reg;

    // a slot keeps its job when it is occupied and not longer than the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            keep[i] = (CNT_W'(i) < count_reg) && (slot_time_reg[i] <= time_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_time_next[i] = slot_time_reg[i];
            slot_tag_next[i]  = slot_tag_reg[i];
        end
        count_next  = count_reg;
        total_next  = total_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        tag_next    = tag_reg;
        otime_next  = otime_reg;
        sum_next    = sum_reg;
        late_next   = late_reg;
        occ_next    = occ_reg;

        if (cmd.execute) begin
            status_next = STATUS_OK;
            tag_next    = '0;
            otime_next  = '0;
            sum_next    = '0;
            late_next   = 1'b0;
            occ_next    = TAG_W'(count_reg);
            if (kind_reg == KIND_ENQ) begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    // shift the tail up one slot and drop the new job in the gap
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (!keep[i]) begin
                            if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                                slot_time_next[i] = time_reg;
                                slot_tag_next[i]  = new_tag;
                            end else begin
                                slot_time_next[i] = slot_time_reg[(i == 0) ? 0 : i - 1];
                                slot_tag_next[i]  = slot_tag_reg[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                    tag_next   = new_tag;
                    occ_next   = TAG_W'(count_reg + CNT_W'(1));
                end
            end else begin
                if (count_reg == '0) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    // advance every job one slot toward the head
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        slot_time_next[i] = slot_time_reg[i + 1];
                        slot_tag_next[i]  = slot_tag_reg[i + 1];
                    end
                    count_next = count_reg - CNT_W'(1);
                    tag_next   = slot_tag_reg[0];
                    otime_next = slot_time_reg[0];
                    sum_next   = sum_sat;
                    late_next  = (slot_tag_reg[0] < pos_inc);
                    occ_next   = TAG_W'(count_reg - CNT_W'(1));
                    if (count_reg == CNT_W'(1)) begin
                        total_next = '0;
                        pos_next   = '0;
                    end else begin
                        total_next = sum_sat;
                        pos_next   = pos_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            time_reg <= in_time;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_time_reg[i] <= slot_time_next[i];
            slot_tag_reg[i]  <= slot_tag_next[i];
        end
        status_reg <= status_next;
        tag_reg    <= tag_next;
        otime_reg  <= otime_next;
        sum_reg    <= sum_next;
        late_reg   <= late_next;
        occ_reg    <= occ_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            pos_reg   <= '0;
        end else begin
            count_reg <= count_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/shortest_job_first_queue_top.sv
// Top level: shortest-job-first queue with stream input and result channels.
// Flow: an accepted transfer is captured, then executed once the output register is free,
// and its result is registered into m_tdata. s_tready stays low from capture until
// execute, so a new item waits for the last one; a stalled result holds execute.
// Reset: aresetn, synchronous, active low; clears occupancy, served time,
// service position and the handshake state. Slot contents are left unset.
`default_nettype none
module shortest_job_first_queue_top
    import sjfq_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] job_time
    input  wire  [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // [4:0] out_tag, [20:5] out_time, [40:21] wait_sum,
                                   // [41] served_late, [46:42] occupancy, [47] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    sjfq_cmd_t           cmd;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [TIME_W-1:0]   out_time;
    logic [SUM_W-1:0]    wait_sum;
    logic                served_late;
    logic [TAG_W-1:0]    occupancy;

    // Controller: accept one transfer, run it, hand the result to the
    // output register once that register is free.
    sjfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: all slots compare against the new time in parallel, so an
    // insert or a removal completes within the execute state.
    sjfq_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_kind       (s_tuser[0]),
        .in_time       (s_tdata[TIME_W-1:0]),
        .out_status    (status),
        .out_tag       (out_tag),
        .out_time      (out_time),
        .out_wait_sum  (wait_sum),
        .out_late      (served_late),
        .out_occupancy (occupancy)
    );

    // Pack result fields from the lowest bit up, pad to whole bytes.
    assign m_tdata = {1'b0, occupancy, served_late, wait_sum, out_time, out_tag};
    assign m_tuser = status;

endmodule
`default_nettype wire

>>> tb/shortest_job_first_queue_top_tb.sv
// Testbench for the shortest-job-first queue: mirrored queue model, stream drivers, checks.
`timescale 1ns / 1ps
`default_nettype none
module shortest_job_first_queue_top_tb;
    import sjfq_pkg::*;

    localparam int RANDOM_ITEMS = 725;
    localparam int LONG_HOLD    = 300;

    // one result transfer, unpacked from m_tdata / m_tuser
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   job_time;
        logic [SUM_W-1:0]    sum;
        logic                late;
        logic [4:0]          occ;
    } job_reply_t;

    // Mirror of the sorted job queue; holds the replies still owed by the block.
    class sjf_queue_mirror;
        bit [TIME_W-1:0] slot_time[QUEUE_DEPTH];
        bit [TAG_W-1:0]  slot_tag[QUEUE_DEPTH];
        int              held;
        bit [SUM_W-1:0]  served_total;
        bit [TAG_W-1:0]  serve_pos;
        job_reply_t      owed_replies[$];
        int              errors;

        function new();
            held = 0;
            served_total = '0;
            serve_pos = '0;
            errors = 0;
        endfunction

        // Advance the mirror by one accepted request and queue the reply it owes.
        function void note_request(logic kind, logic [TIME_W-1:0] jt);
            job_reply_t  r;
            int          pos;
            int          i;
            bit [SUM_W:0] sum;
            r = '0;
            if (kind == KIND_ENQ) begin
                if (held >= QUEUE_DEPTH) begin
                    r.status = STATUS_FULL;
                    r.occ = 5'(held);
                end else begin
                    // equal times keep arrival order: go behind every time not greater
                    pos = 0;
                    while (pos < held && slot_time[pos] <= jt) pos++;
                    for (i = held; i > pos; i--) begin
                        slot_time[i] = slot_time[i-1];
                        slot_tag[i] = slot_tag[i-1];
                    end
                    slot_time[pos] = jt;
                    slot_tag[pos] = 5'(held + 1);
                    held++;
                    r.status = STATUS_OK;
                    r.tag = slot_tag[pos];
                    r.occ = 5'(held);
                end
            end else if (held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.status = STATUS_OK;
                r.tag = slot_tag[0];
                r.job_time = slot_time[0];
                for (i = 1; i < held; i++) begin
                    slot_time[i-1] = slot_time[i];
                    slot_tag[i-1] = slot_tag[i];
                end
                held--;
                sum = {1'b0, served_total} + r.job_time;
                if (sum > SUM_MAX)
                    sum = {1'b0, SUM_MAX};
                served_total = sum[SUM_W-1:0];
                if (serve_pos < POS_MAX)
                    serve_pos++;
                r.sum = served_total;
                r.late = (r.tag < serve_pos);
                r.occ = 5'(held);
                // waiting sum and service position restart on an empty queue
                if (held == 0) begin
                    served_total = '0;
                    serve_pos = '0;
                end
            end
            owed_replies.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // Check one accepted result against the oldest owed reply.
        function void check_reply(logic [47:0] data, logic [1:0] user);
            job_reply_t want;
            if (owed_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual tdata %0h tuser %0h",
                         $time, data, user);
            end else begin
                want = owed_replies.pop_front();
                compare("status", 32'(want.status), 32'(user));
                compare("out_tag", 32'(want.tag), 32'(data[4:0]));
                compare("out_time", 32'(want.job_time), 32'(data[20:5]));
                compare("wait_sum", 32'(want.sum), 32'(data[40:21]));
                compare("served_late", 32'(want.late), 32'(data[41]));
                compare("occupancy", 32'(want.occ), 32'(data[46:42]));
                compare("pad", 32'(0), 32'(data[47]));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    // set by the stimulus to ask the receiver for its long hold-off
    bit long_hold_req = 1'b0;

    sjf_queue_mirror queue_mirror = new();

    shortest_job_first_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // sender burst state: items left in the current burst
    int burst_left = 0;

    // Offer one request and hold it until the block takes the transfer.
    task automatic send_job(logic kind, logic [15:0] jt);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= jt;
        do @(posedge aclk); while (s_tready !== 1'b1);
        queue_mirror.note_request(kind, jt);
    endtask

    // At the end of a burst, start a new burst, mostly after dropping valid for a random gap.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    function automatic logic [15:0] pick_time(int spread);
        case (spread)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));                 // ties
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(16'hF000, 16'hFFFF)); // drives sum to saturation
        endcase
    endfunction

    // Directed pass: empty dequeue, fill with extreme and repeated times,
    // overflow once, then drain part of the queue.
    task automatic run_directed();
        logic [15:0] fill_times[16] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h8000,
                                        16'h5555, 16'hAAAA, 16'h0000, 16'h00FF,
                                        16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3333,
                                        16'hCCCC, 16'h0001, 16'hFFFE, 16'h7FFF};
        pace_sender();
        send_job(KIND_DEQ, 16'hFFFF);
        foreach (fill_times[i]) begin
            pace_sender();
            send_job(KIND_ENQ, fill_times[i]);
        end
        pace_sender();
        send_job(KIND_ENQ, 16'h1234);
        repeat (7) begin
            pace_sender();
            send_job(KIND_DEQ, 16'($urandom));
        end
    endtask

    // Random pass in segments: balanced, sustained (queue never empties, so
    // sum and position saturate), fill-heavy and drain-heavy traffic.
    task automatic run_random(int count);
        int   mode;
        int   seg_left;
        int   spread;
        logic kind;
        seg_left = 0;
        mode = 2;
        for (int n = 0; n < count; n++) begin
            if (seg_left == 0) begin
                mode = $urandom_range(0, 3);
                seg_left = (mode == 1) ? $urandom_range(60, 150) : $urandom_range(20, 60);
                spread = $urandom_range(0, 3);
            end
            seg_left--;
            case (mode)
                1: begin
                    if (queue_mirror.held <= 2)
                        kind = KIND_ENQ;
                    else if (queue_mirror.held >= QUEUE_DEPTH - 1)
                        kind = KIND_DEQ;
                    else
                        kind = $urandom_range(0, 1) ? KIND_DEQ : KIND_ENQ;
                    if ($urandom_range(0, 3) != 0)
                        spread = 3;
                end
                2: kind = ($urandom_range(0, 4) == 0) ? KIND_DEQ : KIND_ENQ;
                3: kind = ($urandom_range(0, 4) == 0) ? KIND_ENQ : KIND_DEQ;
                default: kind = $urandom_range(0, 1) ? KIND_DEQ : KIND_ENQ;
            endcase
            pace_sender();
            send_job(kind, pick_time(spread));
        end
    endtask

    // Receiver: check every result transfer, stall in random phases, and hold
    // off once for a long stretch so the block backs up into its input.
    initial begin : result_sink
        int stall_pct;
        int phase_left;
        int hold_left;
        stall_pct = 0;
        phase_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                queue_mirror.check_reply(m_tdata, m_tuser);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
                phase_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Main sequence: reset, directed pass, random pass, drain, verdict.
    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        long_hold_req = 1'b1;
        run_random(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (queue_mirror.owed_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (queue_mirror.errors == 0 && queue_mirror.owed_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

>>> shortest_job_first_queue_top.f
rtl/sjfq_pkg.sv
rtl/sjfq_ctrl.sv
rtl/sjfq_dp.sv
rtl/shortest_job_first_queue_top.sv
tb/shortest_job_first_queue_top_tb.sv
